// ===== rtl/stx_pkg.sv =====
// Package for the S-expression token scanner.
// Holds token and mode types, the result record and the byte classes.
// No dependencies; every module of the block imports it, the two interfaces do not.
package stx_pkg;

  localparam int unsigned LEN_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MAX        = '1;
  localparam logic [LEN_W-1:0] MAX_SYM_RESET  = 16'd32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [2:0] {
    KIND_SYMBOL = 3'd0,
    KIND_OPEN   = 3'd1,
    KIND_CLOSE  = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_SYMBOL  = 2'd1,
    MODE_ERROR   = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e            kind;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_paren(input logic [7:0] c);
    return (c == CH_OPEN) || (c == CH_CLOSE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_mark(input logic [7:0] c);
    return (c == 8'h3C) || (c == 8'h5F) || (c == 8'h2D) || (c == 8'h2F) ||
           (c == 8'h2A) || (c == 8'h3E) || (c == 8'h21) || (c == 8'h3F);
  endfunction

endpackage

// ===== rtl/stx_byte_if.sv =====
// Valid/ready channel carrying one source byte per transfer.
// Depends on nothing.
interface stx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== rtl/stx_token_if.sv =====
// Valid/ready channel carrying one token result per transfer.
// Depends on nothing.
interface stx_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input last_of_run, output ready);
endinterface

// ===== rtl/sexpr_token_scanner.sv =====
// S-expression token scanner: one source byte in, Lisp-style tokens out.
// Channels: text_in (sink, one text_byte per transfer) and token_out
// (source, kind/start/length/last per transfer); cfg_we_i/cfg_data_i write
// max_symbol_length, taken at any edge with cfg_we_i high.
// Each byte transfer updates the scan state in the same cycle and queues
// zero, one or two tokens; a queued token is registered in the result queue
// and offered on token_out when it reaches the queue head. A byte is taken
// every cycle while the four-entry result queue has room for two tokens;
// bytes that yield two tokens (a pending token ended by a paren or zero byte)
// need two reads from the queue, so the sustained rate is one byte per cycle
// when each byte yields at most one token and token_out is ready. A zero byte
// ends the text: it flushes the pending token, queues an end marker and
// restarts the offset at zero. Reset clears the scan state, the offset and
// the queue and loads 32 into max_symbol_length. When token_out stalls the
// queue fills and text_in ready drops; no token is lost.
// Depends on stx_pkg, stx_byte_if, stx_token_if, stx_scan_core and
// stx_result_queue.
module sexpr_token_scanner import stx_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LEN_W-1:0]   cfg_data_i,
  stx_byte_if.sink           text_in,
  stx_token_if.source        token_out
);

  scan_res_t scan_res;
  token_t    head;
  logic      room;
  logic      take;

  assign text_in.ready = room;
  assign take          = text_in.valid && room;

  stx_scan_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .text_byte_i (text_in.text_byte),
    .scan_res_o  (scan_res)
  );

  stx_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (scan_res),
    .room_o  (room),
    .valid_o (token_out.valid),
    .pop_i   (token_out.ready),
    .head_o  (head)
  );

  assign token_out.token_kind   = head.kind;
  assign token_out.start_offset = head.start;
  assign token_out.token_length = head.len;
  assign token_out.last_of_run  = head.last;

endmodule

// ===== rtl/stx_scan_core.sv =====
// Scanner state and per-byte token decision, up to two results per byte.
// Depends on stx_pkg.
module stx_scan_core import stx_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  input  logic             take_i,
  input  logic [7:0]       text_byte_i,
  output scan_res_t        scan_res_o
);

  logic [LEN_W-1:0]       max_len_q;
  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [LEN_W-1:0]       pstart_q, pstart_d;
  logic [LEN_W-1:0]       plen_q, plen_d;
  logic                   perr_q, perr_d;

  logic             sep;
  logic             flush;
  logic             emit2;
  token_t           flush_tok;
  token_t           emit_tok;
  logic [LEN_W-1:0] here;
  logic [LEN_W-1:0] grown;

  assign here  = LEN_W'(offset_q);
  assign grown = (plen_q == LEN_MAX) ? plen_q : plen_q + 1'b1;
  assign sep   = (text_byte_i == CH_NUL) || is_space(text_byte_i) ||
                 is_paren(text_byte_i);

  always_comb begin
    mode_d    = mode_q;
    pstart_d  = pstart_q;
    plen_d    = plen_q;
    perr_d    = perr_q;
    flush     = 1'b0;
    emit2     = 1'b0;
    flush_tok = '{kind: perr_q ? KIND_ERROR : KIND_SYMBOL, start: pstart_q,
                  len: plen_q, last: 1'b0};
    emit_tok  = '{kind: KIND_END, start: here, len: '0, last: 1'b1};

    if (mode_q != MODE_BETWEEN) begin
      if (sep) begin
        flush    = 1'b1;
        mode_d   = MODE_BETWEEN;
        pstart_d = '0;
        plen_d   = '0;
        perr_d   = 1'b0;
      end else if (mode_q == MODE_SYMBOL &&
                   (is_letter(text_byte_i) || is_digit(text_byte_i) ||
                    is_mark(text_byte_i))) begin
        plen_d = grown;
        if (grown > max_len_q) begin
          perr_d = 1'b1;
        end
      end else begin
        plen_d = grown;
        perr_d = 1'b1;
        mode_d = MODE_ERROR;
      end
    end

    if (mode_q == MODE_BETWEEN || sep) begin
      if (text_byte_i == CH_NUL) begin
        emit2 = 1'b1;
      end else if (is_paren(text_byte_i)) begin
        emit2         = 1'b1;
        emit_tok.kind = (text_byte_i == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
        emit_tok.len  = LEN_W'(1);
      end else if (!is_space(text_byte_i)) begin
        pstart_d = here;
        plen_d   = LEN_W'(1);
        if (is_letter(text_byte_i) || is_mark(text_byte_i)) begin
          mode_d = MODE_SYMBOL;
          perr_d = (max_len_q == '0);
        end else begin
          mode_d = MODE_ERROR;
          perr_d = 1'b1;
        end
      end
    end

    offset_d = (text_byte_i == CH_NUL) ? '0 : offset_q + 1'b1;

    scan_res_o.second = emit_tok;
    if (flush) begin
      flush_tok.last    = !emit2;
      scan_res_o.first  = flush_tok;
      scan_res_o.count  = emit2 ? 2'd2 : 2'd1;
    end else begin
      scan_res_o.first  = emit_tok;
      scan_res_o.count  = emit2 ? 2'd1 : 2'd0;
    end
    if (!take_i) begin
      scan_res_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_SYM_RESET;
      mode_q    <= MODE_BETWEEN;
      offset_q  <= '0;
      pstart_q  <= '0;
      plen_q    <= '0;
      perr_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (take_i) begin
        mode_q   <= mode_d;
        offset_q <= offset_d;
        pstart_q <= pstart_d;
        plen_q   <= plen_d;
        perr_q   <= perr_d;
      end
    end
  end

  a_error_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_ERROR |-> perr_q)
    else $error("error mode without error mark");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_BETWEEN |-> plen_q == '0)
    else $error("pending length left between tokens");

  a_two_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res_o.count == 2'd2 |->
      (scan_res_o.first.kind == KIND_SYMBOL || scan_res_o.first.kind == KIND_ERROR)
      && !scan_res_o.first.last && scan_res_o.second.last)
    else $error("two results without a leading flush");

endmodule

// ===== rtl/stx_result_queue.sv =====
// Small result queue: up to two writes and one read per cycle.
// Depends on stx_pkg.
module stx_result_queue import stx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_res_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      pop_i,
  output token_t    head_o
);

  token_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_q];
  assign room_o  = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop     = pop_i && valid_o;
  assign cnt_d   = cnt_q + QCNT_W'(push_i.count) - QCNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entry_q[wr_q + 1'b1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_W'(push_i.count);
      rd_q  <= rd_q + QPTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> cnt_q <= QCNT_W'(QUEUE_DEPTH - 2))
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPTR_W'(wr_q - rd_q) == QPTR_W'(cnt_q))
    else $error("queue pointers disagree with count");

endmodule

// ===== tb/sexpr_token_checker.sv =====
`timescale 1ns / 1ps
// Token checker for the S-expression scanner testbench: follows byte transfers,
// predicts the tokens they cause and compares them with token transfers.
// Depends on stx_pkg, stx_byte_if and stx_token_if.
module sexpr_token_checker import stx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  stx_byte_if              text_mon,
  stx_token_if             token_mon,
  output int               fail_count_o,
  output int               tokens_due_o
);

  mode_e            scan_mode   = MODE_BETWEEN;
  logic [15:0]      text_offset = '0;
  logic [LEN_W-1:0] tok_start   = '0;
  logic [LEN_W-1:0] tok_len     = '0;
  logic             tok_bad     = 1'b0;
  logic [LEN_W-1:0] max_sym_len = MAX_SYM_RESET;
  token_t           due_tokens[$];
  int               fail_total  = 0;
  int               due_count   = 0;

  assign fail_count_o = fail_total;
  assign tokens_due_o = due_count;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return c inside {CH_OPEN, CH_CLOSE};
  endfunction

  function automatic logic is_sym_head(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], "<", "_", "-", "/", "*", ">", "!", "?"};
  endfunction

  function automatic logic is_sym_body(input logic [7:0] c);
    return is_sym_head(c) || (c inside {[8'h30:8'h39]});
  endfunction

  function automatic token_t make_token(input kind_e k, input logic [LEN_W-1:0] s,
                                        input logic [LEN_W-1:0] l);
    token_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.last  = 1'b0;
    return t;
  endfunction

  task automatic scan_byte(input logic [7:0] c);
    token_t      found[$];
    logic        sep;
    logic [15:0] here;
    sep  = (c == CH_NUL) || is_blank(c) || is_bracket(c);
    here = text_offset;
    if (scan_mode != MODE_BETWEEN) begin
      if (sep) begin
        if (tok_bad) found.push_back(make_token(KIND_ERROR, tok_start, tok_len));
        else found.push_back(make_token(KIND_SYMBOL, tok_start, tok_len));
        scan_mode = MODE_BETWEEN;
        tok_start = '0;
        tok_len   = '0;
        tok_bad   = 1'b0;
      end else if (scan_mode == MODE_SYMBOL && is_sym_body(c)) begin
        if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
        if (tok_len > max_sym_len) tok_bad = 1'b1;
      end else begin
        if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
        tok_bad   = 1'b1;
        scan_mode = MODE_ERROR;
      end
    end
    if (scan_mode == MODE_BETWEEN) begin
      if (c == CH_NUL) begin
        found.push_back(make_token(KIND_END, here, '0));
      end else if (c == CH_OPEN) begin
        found.push_back(make_token(KIND_OPEN, here, 16'd1));
      end else if (c == CH_CLOSE) begin
        found.push_back(make_token(KIND_CLOSE, here, 16'd1));
      end else if (!is_blank(c)) begin
        tok_start = here;
        tok_len   = 16'd1;
        if (is_sym_head(c)) begin
          scan_mode = MODE_SYMBOL;
          tok_bad   = (max_sym_len == '0);
        end else begin
          scan_mode = MODE_ERROR;
          tok_bad   = 1'b1;
        end
      end
    end
    if (found.size() != 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) due_tokens.push_back(found[i]);
    text_offset = (c == CH_NUL) ? 16'd0 : here + 16'd1;
  endtask

  task automatic check_token();
    token_t want;
    if (due_tokens.size() == 0) begin
      $error("unexpected token: token_kind %0d start_offset %0d token_length %0d",
             token_mon.token_kind, token_mon.start_offset, token_mon.token_length);
      fail_total++;
    end else begin
      want = due_tokens.pop_front();
      if (token_mon.token_kind !== want.kind) begin
        $error("token_kind: expected %0d, actual %0d", want.kind, token_mon.token_kind);
        fail_total++;
      end
      if (token_mon.start_offset !== want.start) begin
        $error("start_offset: expected %0d, actual %0d", want.start,
               token_mon.start_offset);
        fail_total++;
      end
      if (token_mon.token_length !== want.len) begin
        $error("token_length: expected %0d, actual %0d", want.len,
               token_mon.token_length);
        fail_total++;
      end
      if (token_mon.last_of_run !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, token_mon.last_of_run);
        fail_total++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode   = MODE_BETWEEN;
      text_offset = '0;
      tok_start   = '0;
      tok_len     = '0;
      tok_bad     = 1'b0;
      max_sym_len = MAX_SYM_RESET;
      due_tokens.delete();
    end else begin
      if (token_mon.valid && token_mon.ready) check_token();
      if (text_mon.valid && text_mon.ready) scan_byte(text_mon.text_byte);
      if (cfg_we_i) max_sym_len = cfg_data_i;
    end
    due_count = due_tokens.size();
  end

endmodule

// ===== tb/tb_sexpr_token_scanner.sv =====
`timescale 1ns / 1ps
// Testbench top for sexpr_token_scanner: clock, reset, byte and register stimulus,
// token sink with stalls, and the verdict from the token checker.
// Depends on stx_pkg, stx_byte_if, stx_token_if, the scanner and sexpr_token_checker.
module tb_sexpr_token_scanner;
  import stx_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned IDLE_PCT     = 10;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam string SYM_FIRST =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ<_-/*>!?";
  localparam string DIGITS    = "0123456789";
  localparam string SYM_REST  = {SYM_FIRST, DIGITS};
  localparam string PUNCT     = "#$%&'\"+,.:;=@[\\]^`{|}~";
  localparam logic [7:0] BLANK_SET [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we_i   = 1'b0;
  logic [LEN_W-1:0] cfg_data_i = MAX_SYM_RESET;
  logic [LEN_W-1:0] cur_max    = MAX_SYM_RESET;
  int               fail_count;
  int               tokens_due;
  bit               steady      = 1'b0;
  int unsigned      hold_left   = 0;
  int unsigned      cycle_count = 0;
  int unsigned      sent        = 0;

  stx_byte_if  text_ch ();
  stx_token_if token_ch ();

  sexpr_token_scanner DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .text_in    (text_ch),
    .token_out  (token_ch)
  );

  sexpr_token_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .text_mon     (text_ch),
    .token_mon    (token_ch),
    .fail_count_o (fail_count),
    .tokens_due_o (tokens_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // token sink: random stalls, plus a long hold-off on request
  initial begin
    token_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        token_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        token_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_stray();
    case ($urandom_range(4))
      0: return pick_from(DIGITS);
      1: return 8'($urandom_range(255, 128));
      2: return pick_from(PUNCT);
      3: return 8'($urandom_range(8, 1));
      default: return $urandom_range(1) ? 8'h7F : 8'($urandom_range(31, 14));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      text_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    do @(posedge clk_i); while (!text_ch.ready);
    sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_symbol(input int unsigned len, input bit with_strays);
    send_byte(pick_from(SYM_FIRST));
    repeat (len - 1) begin
      if (with_strays && $urandom_range(49) == 0) send_byte(pick_stray());
      else send_byte(pick_from(SYM_REST));
    end
  endtask

  // hold the sender until every token has come out
  task automatic drain();
    text_ch.valid <= 1'b0;
    do @(posedge clk_i); while (tokens_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max(input logic [LEN_W-1:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    cur_max = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_text(input int unsigned n_bytes);
    int unsigned stop;
    int unsigned pick;
    int unsigned len;
    stop = sent + n_bytes;
    while (sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = $urandom_range(9);
        if (len == 0 && cur_max != 0 && cur_max <= 64) len = cur_max;
        else if (len == 1 && cur_max <= 64) len = cur_max + 1;
        else len = $urandom_range(8, 1);
        send_symbol(len, 1'b1);
      end else if (pick < 55) begin
        send_byte($urandom_range(1) ? CH_OPEN : CH_CLOSE);
      end else if (pick < 65) begin
        send_byte(pick_stray());
        repeat ($urandom_range(3)) begin
          if ($urandom_range(1)) send_byte(pick_stray());
          else send_byte(pick_from(SYM_REST));
        end
      end else if (pick < 82) begin
        send_byte(BLANK_SET[$urandom_range(5)]);
      end else if (pick < 87) begin
        send_byte(CH_NUL);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    text_ch.valid     = 1'b0;
    text_ch.text_byte = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("(ab)");
    send_text("? 9x");
    send_byte(8'h09);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h0A);
    send_text("a#");
    send_byte(8'h0D);
    send_text("<_-/*>!?");
    send_byte(8'h0B);
    send_text("Z0");
    send_byte(CH_NUL);
    send_byte(CH_NUL);
    send_byte(8'h0C);

    write_max('0);
    send_text("a ");
    write_max(16'd1);
    send_text("b cd");
    send_byte(CH_CLOSE);

    // longest legal symbol, then one just past the limit
    write_max(16'd40);
    send_symbol(40, 1'b0);
    send_byte(8'h20);
    send_symbol(41, 1'b0);
    send_byte(CH_CLOSE);
    send_byte(CH_NUL);

    write_max(16'd4);
    hold_left = LONG_HOLD;
    random_text(340);
    write_max(16'd1);
    steady = 1'b1;
    random_text(200);
    steady = 1'b0;
    random_text(140);
    write_max(16'($urandom_range(65535, 2)));
    random_text(330);
    write_max(16'd12);
    random_text(230);
    drain();

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
